/* rtl/tlbpt_pkg.sv */
`timescale 1ns / 1ps

package tlbpt_pkg;

  localparam int unsigned PageW = 8;
  localparam int unsigned OffW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned FrameOutW = 8;

  typedef enum logic [1:0] {
    ST_TLB_HIT,
    ST_TABLE_HIT,
    ST_FAULT,
    ST_NO_FRAME
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_PAGE,
    S_RED_OFF,
    S_LOOKUP,
    S_DECIDE,
    S_ADDR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             lookup;
    logic             fill;
    logic [PageW-1:0] page;
  } tlb_req_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_req_t;

endpackage

/* rtl/tlbpt_tlb.sv */
`timescale 1ns / 1ps

module tlbpt_tlb #(
  parameter int unsigned Entries = 16,
  parameter int unsigned FrameW  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbpt_pkg::tlb_req_t req_i,
  input  logic [FrameW-1:0]   fill_frame_i,
  output logic                hit_o,
  output logic [FrameW-1:0]   frame_o
);
  import tlbpt_pkg::*;

  localparam int unsigned IdxW = $clog2(Entries);

  logic [PageW-1:0]  page_q [Entries];
  logic [FrameW-1:0] frame_mem_q [Entries];
  logic [Entries-1:0] valid_q;
  logic [Entries-1:0] match;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [IdxW-1:0]   hit_idx;
  logic              hit_q;
  logic [FrameW-1:0] frame_rd_q;

  // A page is held in at most one valid entry, so the matching index can be
  // formed by OR-ing the indexes of all matches.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (page_q[i] == req_i.page);
      if (match[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
  end

  assign ptr_d = (ptr_q == IdxW'(Entries - 1)) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req_i.fill) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q          <= ptr_d;
      end
      if (req_i.lookup) begin
        hit_q <= |match;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.fill) begin
      page_q[ptr_q]      <= req_i.page;
      frame_mem_q[ptr_q] <= fill_frame_i;
    end
    if (req_i.lookup) begin
      frame_rd_q <= frame_mem_q[hit_idx];
    end
  end

  assign hit_o   = hit_q;
  assign frame_o = frame_rd_q;

endmodule

/* rtl/tlbpt_ptab.sv */
`timescale 1ns / 1ps

module tlbpt_ptab #(
  parameter int unsigned Pages  = 256,
  parameter int unsigned FrameW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tlbpt_pkg::tbl_req_t     req_i,
  input  logic [$clog2(Pages)-1:0] rd_addr_i,
  input  logic [$clog2(Pages)-1:0] wr_addr_i,
  input  logic [FrameW-1:0]       wr_frame_i,
  output logic                    rd_valid_o,
  output logic [FrameW-1:0]       rd_frame_o,
  output logic                    ready_o
);
  import tlbpt_pkg::*;

  localparam int unsigned IdxW = $clog2(Pages);

  logic [FrameW:0]   mem_q [Pages];
  logic [FrameW:0]   rd_q;
  logic [IdxW-1:0]   clr_q;
  logic              clearing_q;
  logic              we;
  logic [IdxW-1:0]   wa;
  logic [FrameW:0]   wd;

  assign we = clearing_q || req_i.wr;
  assign wa = clearing_q ? clr_q : wr_addr_i;
  assign wd = clearing_q ? '0 : {1'b1, wr_frame_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == IdxW'(Pages - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (req_i.rd) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_q[FrameW];
  assign rd_frame_o = rd_q[FrameW-1:0];
  assign ready_o    = !clearing_q;

endmodule

/* rtl/tlb_page_table_translate.sv */
`timescale 1ns / 1ps

// Translates a page number and offset into a physical address through a
// FIFO-replaced TLB, a page table and demand allocation of the lowest free
// frame, which is never released. After reset the page table is swept clear
// entry by entry while in_stall_o stays high. One transfer at a time is in
// flight: it steps through S_RED_PAGE and S_RED_OFF, one step for each
// subtraction of PAGE_COUNT from the page or of PAGE_BYTES from the offset
// when either size is below 256, then S_LOOKUP, S_DECIDE, S_ADDR and S_DONE,
// and the next transfer is accepted once the block is back in S_IDLE. The
// registered TLB frame read and the page-table memory read set the lookup
// step, and the frame times page size product has a state of its own. A
// finished result waits in the output register without blocking the next
// transfer in; the next result holds in S_DONE until that register frees.
module tlb_page_table_translate #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned PAGE_BYTES  = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tlbpt_pkg::PageW-1:0]  page_number_i,
  input  logic [tlbpt_pkg::OffW-1:0]   page_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlbpt_pkg::AddrW-1:0]  physical_address_o,
  output logic [tlbpt_pkg::FrameOutW-1:0] frame_number_o,
  output logic [1:0]                   lookup_status_o
);
  import tlbpt_pkg::*;

  localparam int unsigned PidxW = $clog2(PAGE_COUNT);
  localparam int unsigned FrameW = $clog2(FRAME_COUNT);
  localparam int unsigned NextW = $clog2(FRAME_COUNT + 1);
  localparam logic [31:0] PageMod = PAGE_COUNT;
  localparam logic [31:0] OffMod = PAGE_BYTES;

  state_e              state_q, state_d;
  logic [PageW-1:0]    page_q, page_d;
  logic [PageW-1:0]    pred_q, pred_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  status_e             status_q, status_d;
  logic [NextW-1:0]    next_free_q, next_free_d;
  logic [AddrW-1:0]    addr_q, addr_d;

  logic                out_valid_q;
  logic [AddrW-1:0]    out_addr_q;
  logic [FrameOutW-1:0] out_frame_q;
  status_e             out_status_q;
  logic                load_out;

  logic [7:0]          sub_a;
  logic [31:0]         sub_m;
  logic                sub_ge;
  logic [7:0]          sub_diff;

  tlb_req_t            tlb_req;
  logic                tlb_hit;
  logic [FrameW-1:0]   tlb_frame;
  tbl_req_t            tbl_req;
  logic [PidxW-1:0]    pidx;
  logic                tbl_valid;
  logic [FrameW-1:0]   tbl_frame;
  logic                tbl_ready;
  logic [FrameW-1:0]   fill_frame;
  logic                frames_full;

  tlbpt_tlb #(
    .Entries(TLB_ENTRIES),
    .FrameW (FrameW)
  ) u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (tlb_req),
    .fill_frame_i(fill_frame),
    .hit_o       (tlb_hit),
    .frame_o     (tlb_frame)
  );

  tlbpt_ptab #(
    .Pages (PAGE_COUNT),
    .FrameW(FrameW)
  ) u_ptab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_addr_i (pidx),
    .wr_addr_i (pidx),
    .wr_frame_i(fill_frame),
    .rd_valid_o(tbl_valid),
    .rd_frame_o(tbl_frame),
    .ready_o   (tbl_ready)
  );

  // Shared compare and subtract unit for both modulo reductions.
  assign sub_a    = (state_q == S_RED_OFF) ? off_q : pred_q;
  assign sub_m    = (state_q == S_RED_OFF) ? OffMod : PageMod;
  assign sub_ge   = (32'(sub_a) >= sub_m);
  assign sub_diff = 8'(32'(sub_a) - sub_m);

  assign pidx        = PidxW'(32'(pred_q));
  assign frames_full = (next_free_q == NextW'(FRAME_COUNT));
  assign fill_frame  = tbl_valid ? tbl_frame : next_free_q[FrameW-1:0];
  assign in_stall_o  = !((state_q == S_IDLE) && tbl_ready);

  always_comb begin
    state_d      = state_q;
    page_d       = page_q;
    pred_d       = pred_q;
    off_d        = off_q;
    frame_d      = frame_q;
    status_d     = status_q;
    next_free_d  = next_free_q;
    addr_d       = addr_q;
    load_out     = 1'b0;
    tlb_req      = '0;
    tlb_req.page = page_q;
    tbl_req      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          page_d  = page_number_i;
          pred_d  = page_number_i;
          off_d   = page_offset_i;
          state_d = S_RED_PAGE;
        end
      end
      S_RED_PAGE: begin
        if (sub_ge) begin
          pred_d = sub_diff;
        end else begin
          state_d = S_RED_OFF;
        end
      end
      S_RED_OFF: begin
        if (sub_ge) begin
          off_d = sub_diff;
        end else begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        tlb_req.lookup = 1'b1;
        tbl_req.rd     = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        if (tlb_hit) begin
          frame_d  = tlb_frame;
          status_d = ST_TLB_HIT;
        end else if (tbl_valid) begin
          frame_d      = tbl_frame;
          tlb_req.fill = 1'b1;
          status_d     = ST_TABLE_HIT;
        end else if (!frames_full) begin
          frame_d      = next_free_q[FrameW-1:0];
          next_free_d  = next_free_q + 1'b1;
          tlb_req.fill = 1'b1;
          tbl_req.wr   = 1'b1;
          status_d     = ST_FAULT;
        end else begin
          frame_d  = '0;
          status_d = ST_NO_FRAME;
        end
        state_d = S_ADDR;
      end
      S_ADDR: begin
        if (status_q == ST_NO_FRAME) begin
          addr_d = '0;
        end else begin
          addr_d = AddrW'(32'(frame_q) * PAGE_BYTES + 32'(off_q));
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_free_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    pred_q   <= pred_d;
    off_q    <= off_d;
    frame_q  <= frame_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    if (load_out) begin
      out_addr_q   <= addr_q;
      out_frame_q  <= FrameOutW'(32'(frame_q));
      out_status_q <= status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_addr_q;
  assign frame_number_o     = out_frame_q;
  assign lookup_status_o    = out_status_q;

`ifndef SYNTH
  a_rise_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished translation");

  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (lookup_status_o == ST_NO_FRAME)) |->
      ((physical_address_o == '0) && (frame_number_o == '0)))
    else $error("no-free-frame result carries a nonzero address or frame");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= NextW'(FRAME_COUNT))
    else $error("frame allocation ran past the frame count");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_RED_PAGE))
    else $error("accepted transfer did not start a translation");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tlbpt_pkg::*;

  localparam int TLB_SLOTS = 16;
  localparam int PAGES = 256;
  localparam int FRAMES = 256;
  localparam int BYTES_PER_PAGE = 256;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [AddrW-1:0]     addr;
    logic [FrameOutW-1:0] frame;
    status_e              status;
  } xlat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PageW-1:0] page_number_i = '0;
  logic [OffW-1:0] page_offset_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [AddrW-1:0] physical_address_o;
  logic [FrameOutW-1:0] frame_number_o;
  logic [1:0] lookup_status_o;

  logic [PageW-1:0] tlb_pg [TLB_SLOTS];
  int unsigned tlb_fr [TLB_SLOTS];
  bit tlb_ok [TLB_SLOTS];
  int unsigned fill_ptr = 0;
  int unsigned pt_frame [PAGES];
  bit pt_ok [PAGES];
  bit frame_used [FRAMES];

  xlat_t xlat_due [$];
  int error_count = 0;
  int burst_left = 4;
  int stall_mode = 0;
  int stall_left = 0;
  int cycle_count = 0;

  tlb_page_table_translate #(
    .TLB_ENTRIES(TLB_SLOTS),
    .PAGE_COUNT (PAGES),
    .FRAME_COUNT(FRAMES),
    .PAGE_BYTES (BYTES_PER_PAGE)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .page_number_i     (page_number_i),
    .page_offset_i     (page_offset_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .physical_address_o(physical_address_o),
    .frame_number_o    (frame_number_o),
    .lookup_status_o   (lookup_status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between free flow, light, heavy and alternating stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall_i <= ~out_stall_i;
      end
    endcase
  end

  function automatic void tlb_store(logic [PageW-1:0] page, int unsigned frame);
    tlb_pg[fill_ptr] = page;
    tlb_fr[fill_ptr] = frame;
    tlb_ok[fill_ptr] = 1'b1;
    fill_ptr = (fill_ptr + 1) % TLB_SLOTS;
  endfunction

  function automatic xlat_t translate_page(logic [PageW-1:0] page, logic [OffW-1:0] off);
    xlat_t res;
    int unsigned pidx;
    int unsigned frame;
    int unsigned full_addr;
    bit found;
    pidx = page % PAGES;
    frame = 0;
    found = 1'b0;
    res.status = ST_NO_FRAME;
    for (int i = 0; i < TLB_SLOTS; i++) begin
      if (!found && tlb_ok[i] && tlb_pg[i] == page) begin
        frame = tlb_fr[i];
        res.status = ST_TLB_HIT;
        found = 1'b1;
      end
    end
    if (!found && pt_ok[pidx]) begin
      frame = pt_frame[pidx];
      tlb_store(page, frame);
      res.status = ST_TABLE_HIT;
      found = 1'b1;
    end
    if (!found) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (!found && !frame_used[i]) begin
          frame_used[i] = 1'b1;
          frame = i;
          tlb_store(page, frame);
          pt_frame[pidx] = frame;
          pt_ok[pidx] = 1'b1;
          res.status = ST_FAULT;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      full_addr = frame * BYTES_PER_PAGE + (off % BYTES_PER_PAGE);
      res.addr = full_addr[AddrW-1:0];
      res.frame = frame[FrameOutW-1:0];
    end else begin
      res.addr = '0;
      res.frame = '0;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    xlat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (xlat_due.size() == 0) begin
        $display("%0t: unexpected transfer, address %h frame %h status %0d", $time,
                 physical_address_o, frame_number_o, lookup_status_o);
        error_count++;
      end else begin
        want = xlat_due.pop_front();
        if (physical_address_o !== want.addr) begin
          $display("%0t: physical_address expected %h actual %h", $time, want.addr,
                   physical_address_o);
          error_count++;
        end
        if (frame_number_o !== want.frame) begin
          $display("%0t: frame_number expected %h actual %h", $time, want.frame,
                   frame_number_o);
          error_count++;
        end
        if (lookup_status_o !== want.status) begin
          $display("%0t: lookup_status expected %0d actual %0d", $time, want.status,
                   lookup_status_o);
          error_count++;
        end
      end
    end
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input logic [PageW-1:0] page, input logic [OffW-1:0] off);
    in_valid_i <= 1'b1;
    page_number_i <= page;
    page_offset_i <= off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    xlat_due.push_back(translate_page(page, off));
    pace();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (xlat_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_first_touch();
    send_item(8'h00, 8'h00);
    send_item(8'hFF, 8'hFF);
    send_item(8'h00, 8'hFF);
    send_item(8'hFF, 8'h00);
  endtask

  // Fills the TLB past its last slot so that the oldest entries are replaced
  // and must be found again in the page table.
  task automatic test_tlb_refill();
    for (int p = 8'h10; p < 8'h1E; p++) begin
      send_item(p[PageW-1:0], (p % 2) ? 8'hAA : 8'h55);
    end
    send_item(8'h80, 8'h7F);
    send_item(8'h00, 8'h80);
    send_item(8'hFF, 8'h01);
  endtask

  task automatic test_drain_pause();
    repeat (3) send_item(PageW'($urandom_range(0, 255)), OffW'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [PageW-1:0] recent [$];
    logic [PageW-1:0] page;
    int sel;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45 && recent.size() > 0) begin
        page = recent[$urandom_range(0, (recent.size() < 8) ? recent.size() - 1 : 7)];
      end else if (sel < 75 && recent.size() > 0) begin
        page = recent[$urandom_range(0, recent.size() - 1)];
      end else begin
        page = PageW'($urandom_range(0, 255));
      end
      recent.push_front(page);
      if (recent.size() > 32) begin
        void'(recent.pop_back());
      end
      send_item(page, OffW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_first_touch();
    test_tlb_refill();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
